[sv/hmtp_pkg.sv]
// shared types, codes and character helpers for the height map token parser
package hmtp_pkg;

    localparam int TDATA_W = 88;
    localparam int KIND_W  = 2;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_HEX    = 3'd3;
    localparam logic [2:0] PH_GAP    = 3'd4;
    localparam logic [2:0] PH_LEAD   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam logic [23:0] DEFAULT_COLOR_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [11:0]       column;
        logic [11:0]       line_index;
        logic [31:0]       height;
        logic [31:0]       point_color;
        logic              done_res;
    } res_t;

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // bit 4 flags a hex digit, low nibble is its value
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (is_dec(b))
        begin
            v = {1'b1, b[3:0]};
        end
        else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46)))
        begin
            v = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return v;
    endfunction

endpackage

[sv/hmtp_step.sv]
// per byte next state and result logic of the height map token parser
module hmtp_step
    import hmtp_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096,
    parameter int HEIGHT_BITS = 32,
    parameter int CW          = 13,
    parameter int RW          = 13
)
(
    input  logic [7:0]             text_byte,
    input  logic                   end_of_file,
    input  logic [23:0]            default_color,
    input  logic [2:0]             phase,
    input  logic                   negative,
    input  logic [HEIGHT_BITS-1:0] height_acc,
    input  logic [31:0]            color_acc,
    input  logic [1:0]             skip_left,
    input  logic [CW-1:0]          column_count,
    input  logic [RW-1:0]          row_count,
    input  logic                   in_error,
    output logic [2:0]             phase_next,
    output logic                   negative_next,
    output logic [HEIGHT_BITS-1:0] height_acc_next,
    output logic [31:0]            color_acc_next,
    output logic [1:0]             skip_left_next,
    output logic [CW-1:0]          column_count_next,
    output logic [RW-1:0]          row_count_next,
    output logic                   in_error_next,
    output logic                   emit,
    output res_t                   res
);

    localparam int PW  = HEIGHT_BITS + 4;
    localparam int HW  = (HEIGHT_BITS > 32) ? HEIGHT_BITS : 32;
    localparam int CXW = (CW > 12) ? CW : 12;
    localparam int RXW = (RW > 12) ? RW : 12;

    logic                   is_space;
    logic                   is_nl;
    logic [4:0]             hv;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          lim;
    logic                   ovf;

    logic [2:0]             phase_a;
    logic                   neg_a;
    logic [HEIGHT_BITS-1:0] acc_a;
    logic [31:0]            color_a;
    logic [1:0]             skip_a;
    logic [CW-1:0]          col_a;
    logic [RW-1:0]          row_a;
    logic                   err_a;
    logic                   take_fin;
    logic                   nl_fin;

    logic                   fin_req;
    logic                   fin_ok;
    logic                   eof_err;
    logic                   is_err;
    logic                   is_point;
    logic [31:0]            fin_color;
    logic [HW-1:0]          h_ext;
    logic [HW-1:0]          h_val;
    logic [CXW-1:0]         col_ext;
    logic [RXW-1:0]         row_ext;

    assign is_space = (text_byte == CH_SPACE);
    assign is_nl    = (text_byte == CH_NEWLINE);
    assign hv       = hex_val(text_byte);

    // acc * 10 + digit, checked against the signed limit
    assign prod = PW'({height_acc, 3'b000}) + PW'({height_acc, 1'b0}) + PW'(text_byte[3:0]);
    assign lim  = negative ? (PW'(1) << (HEIGHT_BITS - 1))
                           : ((PW'(1) << (HEIGHT_BITS - 1)) - PW'(1));
    assign ovf  = (prod > lim);

    always_comb
    begin
        phase_a  = phase;
        neg_a    = negative;
        acc_a    = height_acc;
        color_a  = color_acc;
        skip_a   = skip_left;
        col_a    = column_count;
        row_a    = row_count;
        err_a    = 1'b0;
        take_fin = 1'b0;
        nl_fin   = 1'b0;
        unique case (phase)
            PH_START, PH_LEAD, PH_GAP:
            begin
                if (is_space)
                begin
                    if (phase != PH_GAP)
                    begin
                        phase_a = PH_LEAD;
                    end
                end
                else if (is_nl && (phase == PH_GAP))
                begin
                    row_a   = row_count + RW'(1);
                    col_a   = '0;
                    phase_a = PH_START;
                end
                else if (text_byte == CH_MINUS)
                begin
                    neg_a   = ~negative;
                    phase_a = PH_LEAD;
                end
                else if (is_dec(text_byte))
                begin
                    acc_a   = HEIGHT_BITS'(text_byte[3:0]);
                    phase_a = PH_DIGITS;
                end
                else
                begin
                    err_a = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (is_dec(text_byte))
                begin
                    if (ovf)
                    begin
                        err_a = 1'b1;
                    end
                    else
                    begin
                        acc_a = prod[HEIGHT_BITS-1:0];
                    end
                end
                else if (text_byte == CH_COMMA)
                begin
                    skip_a  = 2'd2;
                    color_a = '0;
                    phase_a = PH_SKIP;
                end
                else if (is_space)
                begin
                    take_fin = 1'b1;
                end
                else if (is_nl)
                begin
                    take_fin = 1'b1;
                    nl_fin   = 1'b1;
                end
                else
                begin
                    err_a = 1'b1;
                end
            end
            PH_SKIP:
            begin
                skip_a = skip_left - 2'd1;
                if (skip_left == 2'd1)
                begin
                    phase_a = PH_HEX;
                end
            end
            PH_HEX:
            begin
                if (hv[4])
                begin
                    color_a = {color_acc[27:0], hv[3:0]};
                end
                else if (is_space)
                begin
                    take_fin = 1'b1;
                end
                else if (is_nl)
                begin
                    take_fin = 1'b1;
                    nl_fin   = 1'b1;
                end
                else
                begin
                    err_a = 1'b1;
                end
            end
            default:
            begin
                err_a = 1'b1;
            end
        endcase
    end

    // token completion, from a separator or from end of file
    assign fin_req   = take_fin ||
                       (end_of_file && !err_a && ((phase_a == PH_DIGITS) || (phase_a == PH_HEX)));
    assign eof_err   = end_of_file && !err_a && !take_fin &&
                       ((phase_a == PH_LEAD) || (phase_a == PH_SKIP));
    assign fin_ok    = (column_count < CW'(MAX_COLUMNS)) && (row_count < RW'(MAX_ROWS));
    assign is_err    = err_a || eof_err || (fin_req && !fin_ok);
    assign is_point  = fin_req && fin_ok && !err_a;
    assign fin_color = (phase_a == PH_HEX) ? color_a : {8'h00, default_color};

    assign h_ext   = HW'(acc_a);
    assign h_val   = neg_a ? (HW'(0) - h_ext) : h_ext;
    assign col_ext = CXW'(column_count);
    assign row_ext = RXW'(row_count);

    always_comb
    begin
        phase_next        = phase_a;
        negative_next     = neg_a;
        height_acc_next   = acc_a;
        color_acc_next    = color_a;
        skip_left_next    = skip_a;
        column_count_next = col_a;
        row_count_next    = row_a;
        in_error_next     = in_error;
        res               = '0;
        res.done_res      = end_of_file;
        emit              = end_of_file;
        if (in_error)
        begin
            res.kind       = KIND_END;
            phase_next     = phase;
            negative_next  = negative;
            height_acc_next = height_acc;
            color_acc_next = color_acc;
            skip_left_next = skip_left;
            column_count_next = column_count;
            row_count_next = row_count;
        end
        else
        begin
            res.kind = KIND_END;
            if (is_err)
            begin
                emit          = 1'b1;
                res.kind      = KIND_ERROR;
                in_error_next = 1'b1;
            end
            else if (is_point)
            begin
                emit            = 1'b1;
                res.kind        = KIND_POINT;
                res.column      = col_ext[11:0];
                res.line_index  = row_ext[11:0];
                res.height      = h_val[31:0];
                res.point_color = fin_color;
                negative_next   = 1'b0;
                height_acc_next = '0;
                color_acc_next  = '0;
                if (nl_fin)
                begin
                    column_count_next = '0;
                    row_count_next    = row_count + RW'(1);
                    phase_next        = PH_START;
                end
                else
                begin
                    column_count_next = column_count + CW'(1);
                    phase_next        = PH_GAP;
                end
            end
        end
        if (end_of_file)
        begin
            phase_next        = PH_START;
            negative_next     = 1'b0;
            height_acc_next   = '0;
            color_acc_next    = '0;
            skip_left_next    = '0;
            column_count_next = '0;
            row_count_next    = '0;
            in_error_next     = 1'b0;
        end
    end

endmodule

[sv/heightmap_token_parser.sv]
// top level of the height map token parser: input stage, parser state, result stage, apb
// an input transfer is registered in the input stage, and its result in the result stage, on its way to the master side
// throughput: one text byte per cycle while the result stage is free or the byte yields no result
// a byte that yields no result leaves the result stage free for the next one
// reset: rst_n clears parser state, both stage valids and sets default_color to 0xffffff
module heightmap_token_parser
    import hmtp_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096,
    parameter int HEIGHT_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // text_byte
    input  logic               s_axis_tlast,   // end_of_file
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // column, line_index, height, point_color
    output logic [KIND_W-1:0]  m_axis_tuser,   // kind
    output logic               m_axis_tlast,   // done_res
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [23:0]            default_color_reg;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_eof_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   out_res_reg;

    logic [2:0]             phase_reg;
    logic                   negative_reg;
    logic [HEIGHT_BITS-1:0] height_acc_reg;
    logic [31:0]            color_acc_reg;
    logic [1:0]             skip_left_reg;
    logic [CW-1:0]          column_count_reg;
    logic [RW-1:0]          row_count_reg;
    logic                   in_error_reg;

    logic [2:0]             phase_next;
    logic                   negative_next;
    logic [HEIGHT_BITS-1:0] height_acc_next;
    logic [31:0]            color_acc_next;
    logic [1:0]             skip_left_next;
    logic [CW-1:0]          column_count_next;
    logic [RW-1:0]          row_count_next;
    logic                   in_error_next;

    logic                   emit;
    res_t                   res;
    logic                   out_free;
    logic                   adv;
    logic                   in_take;

    hmtp_step #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS),
        .CW          (CW),
        .RW          (RW)
    ) u_step (
        .text_byte         (in_byte_reg),
        .end_of_file       (in_eof_reg),
        .default_color     (default_color_reg),
        .phase             (phase_reg),
        .negative          (negative_reg),
        .height_acc        (height_acc_reg),
        .color_acc         (color_acc_reg),
        .skip_left         (skip_left_reg),
        .column_count      (column_count_reg),
        .row_count         (row_count_reg),
        .in_error          (in_error_reg),
        .phase_next        (phase_next),
        .negative_next     (negative_next),
        .height_acc_next   (height_acc_next),
        .color_acc_next    (color_acc_next),
        .skip_left_next    (skip_left_next),
        .column_count_next (column_count_next),
        .row_count_next    (row_count_next),
        .in_error_next     (in_error_next),
        .emit              (emit),
        .res               (res)
    );

    // stage handshake
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign adv            = in_valid_reg && (!emit || out_free);
    assign s_axis_tready  = !in_valid_reg || adv;
    assign in_take        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = (adv && emit) ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_START;
            negative_reg     <= 1'b0;
            height_acc_reg   <= '0;
            color_acc_reg    <= '0;
            skip_left_reg    <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            in_error_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                phase_reg        <= phase_next;
                negative_reg     <= negative_next;
                height_acc_reg   <= height_acc_next;
                color_acc_reg    <= color_acc_next;
                skip_left_reg    <= skip_left_next;
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                in_error_reg     <= in_error_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eof_reg  <= s_axis_tlast;
        end
        if (adv && emit)
        begin
            out_res_reg <= res;
        end
    end

    // apb register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            default_color_reg <= pwdata[23:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {8'h00, default_color_reg} : 32'h0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.done_res;
    assign m_axis_tdata  = {out_res_reg.point_color, out_res_reg.height,
                            out_res_reg.line_index, out_res_reg.column};

    a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_END)) |-> m_axis_tlast)
        else $error("end of map result without done flag");

    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_POINT)) |-> (m_axis_tdata == '0))
        else $error("error or end result carries payload");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg <= CW'(MAX_COLUMNS))
        else $error("column count beyond limit");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= RW'(MAX_ROWS))
        else $error("row count beyond limit");

endmodule

[sim/hmtp_checker.sv]
`timescale 1ns / 100ps
// checker for the height map token parser: watches the streams, predicts each result and compares
module hmtp_checker
    import hmtp_pkg::*;
#(
    parameter int         MAX_COLUMNS       = 4096,
    parameter int         MAX_ROWS          = 4096,
    parameter int         HEIGHT_BITS       = 32,
    parameter logic [2:0] REG_DEFAULT_COLOR = 3'd0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // text_byte
    input  logic               s_axis_tlast,   // end_of_file
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,   // column, line_index, height, point_color
    input  logic [KIND_W-1:0]  m_axis_tuser,   // kind
    input  logic               m_axis_tlast,   // done_res
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 tokens_in_flight
);

    typedef enum int {TOK_NONE, TOK_POINT, TOK_ERROR} tok_res_t;

    localparam logic [63:0] HEIGHT_TOP = 64'd1 << (HEIGHT_BITS - 1);

    res_t        expected_tokens[$];
    int          fails = 0;

    logic [23:0] dflt_color;
    logic [2:0]  ph;
    logic        neg;
    logic [63:0] hmag;
    logic [31:0] cacc;
    logic [1:0]  skip;
    int unsigned col;
    int unsigned row;
    logic        err;

    logic [11:0] pt_col;
    logic [11:0] pt_row;
    logic [31:0] pt_height;
    logic [31:0] pt_color;

    function automatic void clear_parse();
        ph   = PH_START;
        neg  = 1'b0;
        hmag = 64'd0;
        cacc = 32'd0;
        skip = 2'd0;
        col  = 0;
        row  = 0;
        err  = 1'b0;
    endfunction

    function automatic void next_row();
        row = row + 1;
        col = 0;
        ph  = PH_START;
    endfunction

    function automatic int hex_digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return int'(b) - int'("0");
        end
        if (b >= "a" && b <= "f")
        begin
            return int'(b) - int'("a") + 10;
        end
        if (b >= "A" && b <= "F")
        begin
            return int'(b) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic tok_res_t close_token(input logic [31:0] color);
        logic [63:0] signed_val;
        if (col >= MAX_COLUMNS || row >= MAX_ROWS)
        begin
            return TOK_ERROR;
        end
        signed_val = neg ? (64'd0 - hmag) : hmag;
        pt_col     = col[11:0];
        pt_row     = row[11:0];
        pt_height  = signed_val[31:0];
        pt_color   = color;
        col        = col + 1;
        neg        = 1'b0;
        hmag       = 64'd0;
        cacc       = 32'd0;
        ph         = PH_GAP;
        return TOK_POINT;
    endfunction

    function automatic tok_res_t take_text_byte(input logic [7:0] b);
        tok_res_t    r;
        logic [63:0] lim;
        logic [63:0] d;
        int          h;
        case (ph)
            PH_START, PH_LEAD, PH_GAP:
            begin
                if (b == CH_SPACE)
                begin
                    if (ph != PH_GAP)
                    begin
                        ph = PH_LEAD;
                    end
                    return TOK_NONE;
                end
                if (b == CH_NEWLINE && ph == PH_GAP)
                begin
                    next_row();
                    return TOK_NONE;
                end
                if (b == CH_MINUS)
                begin
                    neg = ~neg;
                    ph  = PH_LEAD;
                    return TOK_NONE;
                end
                if (b >= "0" && b <= "9")
                begin
                    hmag = 64'(b - "0");
                    ph   = PH_DIGITS;
                    return TOK_NONE;
                end
                return TOK_ERROR;
            end
            PH_DIGITS:
            begin
                if (b >= "0" && b <= "9")
                begin
                    lim = neg ? HEIGHT_TOP : HEIGHT_TOP - 64'd1;
                    d   = 64'(b - "0");
                    if (hmag > (lim - d) / 64'd10)
                    begin
                        return TOK_ERROR;
                    end
                    hmag = hmag * 64'd10 + d;
                    return TOK_NONE;
                end
                if (b == CH_COMMA)
                begin
                    skip = 2'd2;
                    cacc = 32'd0;
                    ph   = PH_SKIP;
                    return TOK_NONE;
                end
                if (b == CH_SPACE)
                begin
                    return close_token({8'd0, dflt_color});
                end
                if (b == CH_NEWLINE)
                begin
                    r = close_token({8'd0, dflt_color});
                    if (r == TOK_POINT)
                    begin
                        next_row();
                    end
                    return r;
                end
                return TOK_ERROR;
            end
            PH_SKIP:
            begin
                skip = skip - 2'd1;
                if (skip == 2'd0)
                begin
                    ph = PH_HEX;
                end
                return TOK_NONE;
            end
            PH_HEX:
            begin
                h = hex_digit_value(b);
                if (h >= 0)
                begin
                    cacc = cacc * 32'd16 + 32'(h);
                    return TOK_NONE;
                end
                if (b == CH_SPACE)
                begin
                    return close_token(cacc);
                end
                if (b == CH_NEWLINE)
                begin
                    r = close_token(cacc);
                    if (r == TOK_POINT)
                    begin
                        next_row();
                    end
                    return r;
                end
                return TOK_ERROR;
            end
            default:
            begin
                return TOK_ERROR;
            end
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eof);
        res_t     want;
        tok_res_t r;
        want = '0;
        if (err)
        begin
            if (!eof)
            begin
                return;
            end
            want.kind     = KIND_END;
            want.done_res = 1'b1;
            clear_parse();
            expected_tokens.push_back(want);
            return;
        end
        r = take_text_byte(b);
        if (eof && r == TOK_NONE)
        begin
            if (ph == PH_DIGITS)
            begin
                r = close_token({8'd0, dflt_color});
            end
            else if (ph == PH_HEX)
            begin
                r = close_token(cacc);
            end
            else if (ph == PH_LEAD || ph == PH_SKIP)
            begin
                r = TOK_ERROR;
            end
        end
        if (r == TOK_NONE && !eof)
        begin
            return;
        end
        if (r == TOK_POINT)
        begin
            want.kind        = KIND_POINT;
            want.column      = pt_col;
            want.line_index  = pt_row;
            want.height      = pt_height;
            want.point_color = pt_color;
        end
        else if (r == TOK_ERROR)
        begin
            want.kind = KIND_ERROR;
            err       = 1'b1;
        end
        else
        begin
            want.kind = KIND_END;
        end
        if (eof)
        begin
            want.done_res = 1'b1;
            clear_parse();
        end
        expected_tokens.push_back(want);
    endfunction

    function automatic void check_result();
        res_t got;
        res_t want;
        got.kind        = m_axis_tuser;
        got.column      = m_axis_tdata[11:0];
        got.line_index  = m_axis_tdata[23:12];
        got.height      = m_axis_tdata[55:24];
        got.point_color = m_axis_tdata[87:56];
        got.done_res    = m_axis_tlast;
        if (expected_tokens.size() == 0)
        begin
            fails++;
            if (fails <= 10)
            begin
                $display("unexpected result: kind %0d col %0d row %0d h %0d c %h last %0d",
                         got.kind, got.column, got.line_index, $signed(got.height),
                         got.point_color, got.done_res);
            end
            return;
        end
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.column !== want.column ||
            got.line_index !== want.line_index || got.height !== want.height ||
            got.point_color !== want.point_color || got.done_res !== want.done_res)
        begin
            fails++;
            if (fails <= 10)
            begin
                $display("mismatch: exp kind %0d col %0d row %0d h %0d c %h last %0d",
                         want.kind, want.column, want.line_index, $signed(want.height),
                         want.point_color, want.done_res);
                $display("          got kind %0d col %0d row %0d h %0d c %h last %0d",
                         got.kind, got.column, got.line_index, $signed(got.height),
                         got.point_color, got.done_res);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_color = DEFAULT_COLOR_RESET;
            clear_parse();
            expected_tokens.delete();
            tokens_in_flight <= 0;
            fail_count       <= fails;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_DEFAULT_COLOR)
            begin
                dflt_color = pwdata[23:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
            end
            tokens_in_flight <= expected_tokens.size();
            fail_count       <= fails;
        end
    end

endmodule

[sim/tb_heightmap_token_parser.sv]
`timescale 1ns / 100ps
// testbench top for the height map token parser: clock, reset, text stimulus, apb writes, verdict
module tb_heightmap_token_parser;
    import hmtp_pkg::*;

    localparam int         MAX_COLUMNS       = 4096;
    localparam int         MAX_ROWS          = 4096;
    localparam int         HEIGHT_BITS       = 32;
    localparam logic [2:0] REG_DEFAULT_COLOR = 3'd0;
    localparam int         RANDOM_BYTES      = 1050;
    localparam int         CFG_INTERVAL      = 300;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = 8'd0;   // text_byte
    logic               s_axis_tlast  = 1'b0;   // end_of_file
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;           // column, line_index, height, point_color
    logic [KIND_W-1:0]  m_axis_tuser;           // kind
    logic               m_axis_tlast;           // done_res
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = 3'd0;
    logic [31:0]        pwdata        = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    int                 fail_count;
    int                 tokens_in_flight;

    logic [7:0]         map_bytes[$];
    int                 sent_count = 0;
    int                 burst_left = 0;

    rx_mode_t           rx_mode    = RX_ALWAYS;
    int                 rx_left    = 0;
    int                 rx_tick    = 0;

    always #10 clk = ~clk;

    heightmap_token_parser #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hmtp_checker #(
        .MAX_COLUMNS       (MAX_COLUMNS),
        .MAX_ROWS          (MAX_ROWS),
        .HEIGHT_BITS       (HEIGHT_BITS),
        .REG_DEFAULT_COLOR (REG_DEFAULT_COLOR)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tlast     (m_axis_tlast),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .tokens_in_flight (tokens_in_flight)
    );

    // result side backpressure, switching between a few stall patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:    m_axis_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic send_map();
        for (int i = 0; i < map_bytes.size(); i++)
        begin
            send_byte(map_bytes[i], i == map_bytes.size() - 1);
        end
        map_bytes.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        map_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            map_bytes.push_back(s[i]);
        end
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_map();
    endtask

    // wait for every expected result, then let in-flight bytes settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tokens_in_flight != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_color(input logic [23:0] color);
        apb_write(REG_DEFAULT_COLOR, {8'($urandom_range(0, 255)), color});
    endtask

    task automatic add_token();
        longint unsigned mag;
        int              n;
        string           hex_chars = "0123456789abcdefABCDEF";
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) add_text(($urandom_range(0, 2) == 0) ? " " : "-");
        case ($urandom_range(0, 7))
            0, 1, 2: mag = $urandom_range(0, 999);
            3, 4:    mag = $urandom;
            5:       mag = 64'd2147483640 + $urandom_range(0, 15);
            6:       mag = $urandom_range(0, 9);
            default: mag = {$urandom, $urandom} % 64'd100000000000;
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            add_text("0");
        end
        add_text($sformatf("%0d", mag));
        if ($urandom_range(0, 2) == 0)
        begin
            add_text(",");
            if ($urandom_range(0, 5) == 0)
            begin
                add_byte(8'($urandom_range(0, 255)));
                add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_text("0x");
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 6;
            repeat (n) add_byte(hex_chars[$urandom_range(0, 21)]);
        end
    endtask

    task automatic add_map();
        int rows;
        int toks;
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
        begin
            toks = $urandom_range(1, 6);
            for (int t = 0; t < toks; t++)
            begin
                if (t > 0)
                begin
                    add_text(($urandom_range(0, 3) == 0) ? "  " : " ");
                end
                add_token();
            end
            if (r < rows - 1 || $urandom_range(0, 1) == 1)
            begin
                add_text(($urandom_range(0, 4) == 0) ? " \n" : "\n");
            end
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int goal;
        int next_cfg;
        int keep;
        int sel;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_color(24'hFFFFFF);

        // directed maps
        send_text("0");
        send_text("2147483647 -2147483648 --7 - -3\n12,0xFFaa00 5,0x\n");
        send_text("7,0x123456789");
        send_text("9 ");
        send_text("8,0x");
        send_text("4,zz1F\n6,0xABCDEF");
        send_text("2147483648");
        send_text("-2147483649\n");
        send_text("-\n");
        send_text("  ");
        send_text("\n5");
        add_byte(8'h00);
        send_map();
        add_text("1");
        add_byte(8'h0D);
        send_text("\n");
        send_text("5,0");
        send_text("3 x 4 5\n");
        send_text("1 2\n \n");
        add_byte(8'hFF);
        send_map();
        drain();
        write_color(24'($urandom));

        goal     = sent_count + RANDOM_BYTES;
        next_cfg = sent_count + CFG_INTERVAL;
        while (sent_count < goal)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 15)
            begin
                add_map();
            end
            else if (sel < 18)
            begin
                add_map();
                if ($urandom_range(0, 1) == 0)
                begin
                    map_bytes[$urandom_range(0, map_bytes.size() - 1)] = 8'($urandom_range(0, 255));
                end
                else
                begin
                    keep = $urandom_range(1, map_bytes.size());
                    while (map_bytes.size() > keep)
                    begin
                        void'(map_bytes.pop_back());
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            end
            send_map();
            if (sent_count >= next_cfg)
            begin
                drain();
                case ($urandom_range(0, 3))
                    0:       write_color(24'h000000);
                    1:       write_color(24'hFFFFFF);
                    default: write_color(24'($urandom));
                endcase
                next_cfg = sent_count + CFG_INTERVAL;
            end
        end

        drain();
        if (fail_count == 0 && tokens_in_flight == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
